// File: design/saao_pkg.sv
// shared constants, codes and types of the footprint area unit
package saao_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 8;
    localparam int AREA_FRAC   = 16;
    localparam int AREA_WIDTH  = 64;
    localparam int MODE_WIDTH  = 2;
    localparam int MUL_WIDTH   = 33;
    localparam int IN_DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam logic [31:0] QUARTER_PI_Q32 = 32'hC90FDAA2;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_BOX  = 2'd0,
        MODE_CYL  = 2'd1,
        MODE_POLY = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        OP_BOX,
        OP_CYL,
        OP_VSTART,
        OP_VNEXT
    } op_kind_t;

    typedef struct packed {
        op_kind_t                        kind;
        logic                            last;
        logic signed [COORD_WIDTH-1:0]   x;
        logic signed [COORD_WIDTH-1:0]   y;
    } op_entry_t;

    typedef struct packed {
        logic      push;
        op_entry_t entry;
    } op_push_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B1,
        ST_B2,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_C4,
        ST_VS,
        ST_V1,
        ST_V2,
        ST_V3,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_OUT
    } back_state_t;

endpackage

// File: design/saao_front.sv
// front end: accepts items, tracks the open polygon and classifies into operations
module saao_front
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [saao_pkg::IN_DATA_WIDTH-1:0]        s_axis_tdata,
    input  logic                                      s_axis_tlast,
    input  logic [saao_pkg::MODE_WIDTH-1:0]           s_axis_tuser,
    input  logic                                      queue_full,
    output saao_pkg::op_push_t                        op_push
);

    logic open_reg;
    logic open_next;
    logic xfer;

    assign s_axis_tready = !queue_full;
    assign xfer          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        open_next            = open_reg;
        op_push.push         = 1'b0;
        op_push.entry.kind   = saao_pkg::OP_BOX;
        op_push.entry.last   = s_axis_tlast;
        op_push.entry.x      = s_axis_tdata[saao_pkg::COORD_WIDTH-1:0];
        op_push.entry.y      = s_axis_tdata[2*saao_pkg::COORD_WIDTH-1:saao_pkg::COORD_WIDTH];
        case (saao_pkg::mode_t'(s_axis_tuser))
            saao_pkg::MODE_BOX:
            begin
                op_push.push       = xfer;
                op_push.entry.kind = saao_pkg::OP_BOX;
                if (xfer)
                begin
                    open_next = 1'b0;
                end
            end
            saao_pkg::MODE_CYL:
            begin
                op_push.push       = xfer;
                op_push.entry.kind = saao_pkg::OP_CYL;
                if (xfer)
                begin
                    open_next = 1'b0;
                end
            end
            saao_pkg::MODE_POLY:
            begin
                op_push.push       = xfer;
                op_push.entry.kind = open_reg ? saao_pkg::OP_VNEXT : saao_pkg::OP_VSTART;
                if (xfer)
                begin
                    open_next = !s_axis_tlast;
                end
            end
            default:
            begin
                op_push.push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

endmodule

// File: design/saao_queue.sv
// two-entry operation queue between front and back
module saao_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  saao_pkg::op_push_t      op_push,
    output logic                    full,
    output logic                    empty,
    input  logic                    pop,
    output saao_pkg::op_entry_t     head
);

    saao_pkg::op_entry_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = op_push.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= op_push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/saao_back.sv
// back end: sequencer around one shared multiplier, accumulator and output register
module saao_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 empty,
    output logic                                 pop,
    input  saao_pkg::op_entry_t                  head,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [saao_pkg::AREA_WIDTH-1:0]      m_axis_tdata,
    output logic [0:0]                           m_axis_tuser
);

    localparam int MW = saao_pkg::MUL_WIDTH;
    localparam int AW = saao_pkg::AREA_WIDTH;
    localparam int CW = saao_pkg::COORD_WIDTH;

    saao_pkg::back_state_t state_reg;
    saao_pkg::back_state_t state_next;
    saao_pkg::op_entry_t   cur_reg;
    saao_pkg::op_entry_t   cur_next;
    logic signed [CW-1:0]  first_x_reg;
    logic signed [CW-1:0]  first_x_next;
    logic signed [CW-1:0]  first_y_reg;
    logic signed [CW-1:0]  first_y_next;
    logic signed [CW-1:0]  prev_x_reg;
    logic signed [CW-1:0]  prev_x_next;
    logic signed [CW-1:0]  prev_y_reg;
    logic signed [CW-1:0]  prev_y_next;
    logic [AW-1:0]         acc_reg;
    logic [AW-1:0]         acc_next;
    logic [AW-1:0]         prod_reg;
    logic [AW-1:0]         prod_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [AW-1:0]         area_reg;
    logic [AW-1:0]         area_next;
    logic                  cw_reg;
    logic                  cw_next;
    logic signed [MW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic signed [2*MW-1:0] mul_full;
    logic                  is_poly;

    function automatic logic signed [MW-1:0] ext_coord(input logic signed [CW-1:0] v);
        ext_coord = MW'(v);
    endfunction

    function automatic logic signed [MW-1:0] ext_u32(input logic [31:0] v);
        ext_u32 = $signed({{(MW-32){1'b0}}, v});
    endfunction

    function automatic logic [AW-1:0] to_q16(input logic [AW-1:0] v, input int fin);
        if (fin > saao_pkg::AREA_FRAC)
        begin
            to_q16 = AW'($signed(v) >>> (fin - saao_pkg::AREA_FRAC));
        end
        else if (fin < saao_pkg::AREA_FRAC)
        begin
            to_q16 = v << (saao_pkg::AREA_FRAC - fin);
        end
        else
        begin
            to_q16 = v;
        end
    endfunction

    assign mul_full      = mul_a * mul_b;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = area_reg;
    assign m_axis_tuser  = cw_reg;
    assign is_poly       = (cur_reg.kind == saao_pkg::OP_VSTART) ||
                           (cur_reg.kind == saao_pkg::OP_VNEXT);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        acc_next       = acc_reg;
        area_next      = area_reg;
        cw_next        = cw_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        pop            = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        case (state_reg)
            saao_pkg::ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    case (head.kind)
                        saao_pkg::OP_BOX:    state_next = saao_pkg::ST_B1;
                        saao_pkg::OP_CYL:    state_next = saao_pkg::ST_C1;
                        saao_pkg::OP_VSTART: state_next = saao_pkg::ST_VS;
                        saao_pkg::OP_VNEXT:  state_next = saao_pkg::ST_V1;
                        default:             state_next = saao_pkg::ST_IDLE;
                    endcase
                end
            end
            saao_pkg::ST_B1:
            begin
                mul_a      = ext_coord(cur_reg.x);
                mul_b      = ext_coord(cur_reg.y);
                state_next = saao_pkg::ST_B2;
            end
            saao_pkg::ST_B2:
            begin
                acc_next   = prod_reg;
                state_next = saao_pkg::ST_OUT;
            end
            saao_pkg::ST_C1:
            begin
                mul_a      = ext_coord(cur_reg.x);
                mul_b      = ext_coord(cur_reg.x);
                state_next = saao_pkg::ST_C2;
            end
            saao_pkg::ST_C2:
            begin
                // low word of the squared diameter times pi/4
                mul_a      = ext_u32(prod_reg[31:0]);
                mul_b      = ext_u32(saao_pkg::QUARTER_PI_Q32);
                acc_next   = prod_reg;
                state_next = saao_pkg::ST_C3;
            end
            saao_pkg::ST_C3:
            begin
                // high word times pi/4
                mul_a      = ext_u32(acc_reg[63:32]);
                mul_b      = ext_u32(saao_pkg::QUARTER_PI_Q32);
                acc_next   = {32'd0, prod_reg[63:32]};
                state_next = saao_pkg::ST_C4;
            end
            saao_pkg::ST_C4:
            begin
                acc_next   = acc_reg + prod_reg;
                state_next = saao_pkg::ST_OUT;
            end
            saao_pkg::ST_VS:
            begin
                first_x_next = cur_reg.x;
                first_y_next = cur_reg.y;
                prev_x_next  = cur_reg.x;
                prev_y_next  = cur_reg.y;
                acc_next     = '0;
                state_next   = cur_reg.last ? saao_pkg::ST_K1 : saao_pkg::ST_IDLE;
            end
            saao_pkg::ST_V1:
            begin
                mul_a      = ext_coord(prev_x_reg);
                mul_b      = ext_coord(cur_reg.y);
                state_next = saao_pkg::ST_V2;
            end
            saao_pkg::ST_V2:
            begin
                acc_next   = acc_reg + prod_reg;
                mul_a      = ext_coord(cur_reg.x);
                mul_b      = ext_coord(prev_y_reg);
                state_next = saao_pkg::ST_V3;
            end
            saao_pkg::ST_V3:
            begin
                acc_next    = acc_reg - prod_reg;
                prev_x_next = cur_reg.x;
                prev_y_next = cur_reg.y;
                state_next  = cur_reg.last ? saao_pkg::ST_K1 : saao_pkg::ST_IDLE;
            end
            saao_pkg::ST_K1:
            begin
                // closing edge back to the first vertex
                mul_a      = ext_coord(cur_reg.x);
                mul_b      = ext_coord(first_y_reg);
                state_next = saao_pkg::ST_K2;
            end
            saao_pkg::ST_K2:
            begin
                acc_next   = acc_reg + prod_reg;
                mul_a      = ext_coord(first_x_reg);
                mul_b      = ext_coord(cur_reg.y);
                state_next = saao_pkg::ST_K3;
            end
            saao_pkg::ST_K3:
            begin
                acc_next   = acc_reg - prod_reg;
                state_next = saao_pkg::ST_OUT;
            end
            saao_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    if (is_poly)
                    begin
                        area_next = to_q16(acc_reg, 2 * saao_pkg::FRAC_BITS + 1);
                        cw_next   = acc_reg[AW-1];
                    end
                    else
                    begin
                        area_next = to_q16(acc_reg, 2 * saao_pkg::FRAC_BITS);
                        cw_next   = 1'b0;
                    end
                    state_next = saao_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = saao_pkg::ST_IDLE;
            end
        endcase
        prod_next = mul_full[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= saao_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        area_reg    <= area_next;
        cw_reg      <= cw_next;
    end

endmodule

// File: design/shape_area_and_orientation.sv
// top level of the footprint area unit: box, cylinder and polygon shoelace area
//
// channel  direction  tdata                              tuser            tlast
// s_axis   in         value_x [23:0], value_y [47:24]    mode [1:0]       last_vertex
// m_axis   out        area [63:0]                        clockwise [0]    none
//
// the front takes one transfer per cycle while the two-entry queue has room
// the back shares one 33x33 multiplier: a box takes one product, a cylinder the squared diameter
// and two with pi/4, a vertex two (none for a first vertex), a last vertex two more to close
// mode 3 transfers are taken and dropped; a result waits in the output register
// while the back goes on; reset clears the queue, the polygon state and the output valid
module shape_area_and_orientation
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [saao_pkg::IN_DATA_WIDTH-1:0]   s_axis_tdata,   // value_x, value_y
    input  logic                                 s_axis_tlast,
    input  logic [saao_pkg::MODE_WIDTH-1:0]      s_axis_tuser,   // mode
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [saao_pkg::AREA_WIDTH-1:0]      m_axis_tdata,   // area
    output logic [0:0]                           m_axis_tuser    // clockwise
);

    saao_pkg::op_push_t  op_push;
    saao_pkg::op_entry_t head;
    logic                queue_full;
    logic                queue_empty;
    logic                pop;

    saao_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .op_push       (op_push)
    );

    saao_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_push (op_push),
        .full    (queue_full),
        .empty   (queue_empty),
        .pop     (pop),
        .head    (head)
    );

    saao_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (queue_empty),
        .pop           (pop),
        .head          (head),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
